// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent checks, clocked on clk and disabled while arst_n is low.
`define KBHI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define KBHI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- hw/rtl/kbhi_pkg.sv -----
`default_nettype none
package kbhi_pkg;
	localparam int BUCKETS     = 512;
	localparam int WAYS        = 2;
	localparam int MAX_KEY_LEN = 20;

	localparam int BUCKET_W = $clog2(BUCKETS);
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int SLOT_W   = BUCKET_W + WAY_W;
	localparam int KIDX_W   = $clog2(MAX_KEY_LEN);
	localparam int KLEN_W   = $clog2(MAX_KEY_LEN + 1);
	localparam int BADDR_W  = SLOT_W + KIDX_W;
	localparam int HASH_W   = 32;
	localparam int HCNT_W   = $clog2(HASH_W);
	localparam int TS_W     = 10;
	localparam int MULT_W   = 16;
	localparam int CFG_W    = 16;

	localparam logic [TS_W-1:0]   TS_RESET   = TS_W'(512);
	localparam logic [MULT_W-1:0] MULT_RESET = MULT_W'(11);
	localparam logic [TS_W-1:0]   TS_MAX     = TS_W'(BUCKETS);

	localparam logic CFG_TABLE_SIZE = 1'b0;
	localparam logic CFG_MULT       = 1'b1;
	localparam logic MODE_KEY       = 1'b0;
	localparam logic MODE_CLEAR     = 1'b1;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_TOO_LONG  = 3'd3,
		ST_CLEARED   = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_CLR, S_DIV, S_LOOK, S_CHK, S_CMPR, S_CMPC, S_WR, S_FIN
	} state_t;

	function automatic logic [7:0] fold_case(input logic [7:0] b);
		if (b >= 8'h41 && b <= 8'h5A) return b + 8'h20;
		return b;
	endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/kbhi_ram.sv -----
`default_nettype none
module kbhi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- hw/rtl/keyword_bucket_hash_inserter.sv -----
// Channel | Signals                                        | Word
// in      | in_valid, in_ready, mode, key_byte, key_last   | one key byte or a clear
// out     | out_valid, out_ready, status, bucket_index,    | one result per last byte
//         | slot_index, hash_value                         | or clear
// cfg     | cfg_we, cfg_index, cfg_data                    | register write, no wait
// A non-last byte does one 32x16 multiply-add on the running hash.
// A last byte: bit-serial modulo, then a lookup and a check per way probed,
// a read and a compare per byte compared and a write per byte stored.
// A clear word sweeps all BUCKETS (512) valid rows, then reports.
// After reset the same sweep runs with in_ready low; cfg writes go on.
// A result waits in the output register; the final step stalls only behind an untaken one.
`default_nettype none
`include "assert_macros.svh"
module keyword_bucket_hash_inserter import kbhi_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              mode,
	input  wire logic [7:0]        key_byte,
	input  wire logic              key_last,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [2:0]             status,
	output logic [8:0]             bucket_index,
	output logic                   slot_index,
	output logic [31:0]            hash_value,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data
);
	state_t state_q, state_d;

	logic [TS_W-1:0]     nbuckets_q, ts_q;
	logic [MULT_W-1:0]   mult_q;
	logic [HASH_W-1:0]   hash_q, dq_q;
	logic [KLEN_W-1:0]   key_len_q;
	logic                overflow_q;
	logic [7:0]          kbuf_q [MAX_KEY_LEN];
	logic [BUCKET_W:0]   rem_q;
	logic [HCNT_W-1:0]   cnt_q;
	logic [BUCKET_W-1:0] bucket_q, sweep_q;
	logic [WAY_W-1:0]    way_q;
	logic [KIDX_W-1:0]   idx_q;
	status_t             res_q;

	// result register
	logic                out_valid_q;
	status_t             status_q;
	logic [BUCKET_W-1:0] bucket_out_q;
	logic [WAY_W-1:0]    slot_out_q;
	logic [HASH_W-1:0]   hash_out_q;

	logic                accept, fin_go;
	logic [HASH_W-1:0]   hash_next;
	logic [BUCKET_W+1:0] trial;
	logic                trial_ge;
	logic [WAYS-1:0]     vrow;
	logic [KLEN_W-1:0]   slen;
	logic [7:0]          sbyte;
	logic                idx_end;
	logic                way_end;
	logic [SLOT_W-1:0]   slot;

	logic                v_we, l_we, b_we;
	logic [BUCKET_W-1:0] v_waddr;
	logic [WAYS-1:0]     v_wdata;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign hash_next = HASH_W'(hash_q * HASH_W'(mult_q)) + HASH_W'(fold_case(key_byte));
	assign trial     = {rem_q, dq_q[HASH_W-1]};
	assign trial_ge  = trial >= (BUCKET_W+2)'(ts_q);
	assign slot      = {bucket_q, way_q};
	assign idx_end   = ((KLEN_W'(idx_q) + KLEN_W'(1)) == key_len_q);
	assign way_end   = (way_q == WAY_W'(WAYS - 1));
	assign fin_go    = !out_valid_q || out_ready;

	// valid rows: one row per bucket, one bit per way
	kbhi_ram #(.WIDTH(WAYS), .DEPTH(BUCKETS)) u_valid (
		.clk, .we(v_we), .waddr(v_waddr), .wdata(v_wdata), .raddr(bucket_q), .rdata(vrow)
	);
	kbhi_ram #(.WIDTH(KLEN_W), .DEPTH(2**SLOT_W)) u_len (
		.clk, .we(l_we), .waddr(slot), .wdata(key_len_q), .raddr(slot), .rdata(slen)
	);
	kbhi_ram #(.WIDTH(8), .DEPTH(2**BADDR_W)) u_bytes (
		.clk, .we(b_we), .waddr({slot, idx_q}), .wdata(kbuf_q[idx_q]),
		.raddr({slot, idx_q}), .rdata(sbyte)
	);

	always_comb begin
		state_d = state_q;
		v_we    = 1'b0;
		v_waddr = sweep_q;
		v_wdata = '0;
		l_we    = 1'b0;
		b_we    = 1'b0;
		unique case (state_q)
			S_INIT, S_CLR: begin
				v_we = 1'b1;
				if (sweep_q == BUCKET_W'(BUCKETS - 1))
					state_d = (state_q == S_INIT) ? S_IDLE : S_FIN;
			end
			S_IDLE: begin
				if (accept) begin
					if (mode == MODE_CLEAR) state_d = S_CLR;
					else if (key_last) state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (cnt_q == HCNT_W'(HASH_W - 1))
					state_d = overflow_q ? S_FIN : S_LOOK;
			end
			S_LOOK: state_d = S_CHK;
			S_CHK: begin
				if (!vrow[way_q]) state_d = S_WR;
				else if (slen == key_len_q) state_d = S_CMPR;
				else state_d = way_end ? S_FIN : S_LOOK;
			end
			S_CMPR: state_d = S_CMPC;
			S_CMPC: begin
				if (sbyte != kbuf_q[idx_q]) state_d = way_end ? S_FIN : S_LOOK;
				else if (idx_end) state_d = S_FIN;
				else state_d = S_CMPR;
			end
			S_WR: begin
				b_we = 1'b1;
				if (idx_end) begin
					l_we    = 1'b1;
					v_we    = 1'b1;
					v_waddr = bucket_q;
					v_wdata = vrow | (WAYS'(1) << way_q);
					state_d = S_FIN;
				end
			end
			S_FIN: if (fin_go) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_INIT;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nbuckets_q   <= TS_RESET;
			mult_q       <= MULT_RESET;
			hash_q       <= '0;
			key_len_q    <= '0;
			overflow_q   <= 1'b0;
			sweep_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_TABLE_SIZE) nbuckets_q <= cfg_data[TS_W-1:0];
				else mult_q <= cfg_data[MULT_W-1:0];
			end
			if (state_q == S_INIT || state_q == S_CLR) sweep_q <= sweep_q + 1'b1;
			if (state_q == S_FIN && fin_go) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (accept) begin
				if (mode == MODE_CLEAR) begin
					hash_q     <= '0;
					key_len_q  <= '0;
					overflow_q <= 1'b0;
				end else begin
					hash_q <= hash_next;
					if (key_len_q < KLEN_W'(MAX_KEY_LEN)) key_len_q <= key_len_q + 1'b1;
					else overflow_q <= 1'b1;
				end
			end
			if (state_q == S_FIN && fin_go) begin
				hash_q      <= '0;
				key_len_q   <= '0;
				overflow_q  <= 1'b0;
			end
		end
	end

	// payload and sequencer datapath
	always_ff @(posedge clk) begin
		if (accept && mode == MODE_KEY && key_len_q < KLEN_W'(MAX_KEY_LEN))
			kbuf_q[key_len_q[KIDX_W-1:0]] <= key_byte;
		if (accept) begin
			dq_q  <= hash_next;
			rem_q <= '0;
			cnt_q <= '0;
			way_q <= '0;
			idx_q <= '0;
			res_q <= (mode == MODE_CLEAR) ? ST_CLEARED : ST_FULL;
			// out-of-range sizes clamp to 1..BUCKETS
			if (nbuckets_q == '0) ts_q <= TS_W'(1);
			else if (nbuckets_q > TS_MAX) ts_q <= TS_MAX;
			else ts_q <= nbuckets_q;
		end
		unique case (state_q)
			S_DIV: begin
				dq_q  <= {dq_q[HASH_W-2:0], 1'b0};
				rem_q <= trial_ge ? (BUCKET_W+1)'(trial - (BUCKET_W+2)'(ts_q))
				                  : (BUCKET_W+1)'(trial);
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == HCNT_W'(HASH_W - 1)) begin
					bucket_q <= trial_ge ? BUCKET_W'(trial - (BUCKET_W+2)'(ts_q))
					                     : BUCKET_W'(trial);
					if (overflow_q) res_q <= ST_TOO_LONG;
				end
			end
			S_CHK: begin
				idx_q <= '0;
				if (!vrow[way_q]) res_q <= ST_INSERTED;
				else if (slen != key_len_q && !way_end) way_q <= way_q + 1'b1;
			end
			S_CMPC: begin
				if (sbyte != kbuf_q[idx_q]) begin
					if (!way_end) way_q <= way_q + 1'b1;
				end else if (idx_end) res_q <= ST_DUPLICATE;
				else idx_q <= idx_q + 1'b1;
			end
			S_WR: if (!idx_end) idx_q <= idx_q + 1'b1;
			S_FIN: begin
				if (fin_go) begin
					status_q     <= res_q;
					bucket_out_q <= (res_q == ST_CLEARED) ? '0 : bucket_q;
					slot_out_q   <= (res_q == ST_INSERTED || res_q == ST_DUPLICATE)
					                ? way_q : '0;
					hash_out_q   <= (res_q == ST_CLEARED) ? '0 : hash_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign bucket_index = bucket_out_q;
	assign slot_index   = slot_out_q;
	assign hash_value   = hash_out_q;

	`KBHI_ASSERT_IMP(a_rem_bound, state_q == S_DIV, rem_q < (BUCKET_W+1)'(ts_q), "remainder escaped modulus")
	`KBHI_ASSERT_IMP(a_wr_empty, state_q == S_WR, !vrow[way_q], "storing into a valid slot")
	`KBHI_ASSERT_NXT(a_fin_load, state_q == S_FIN && fin_go, out_valid_q, "result not loaded")
	`KBHI_ASSERT_IMP(a_no_short, state_q == S_LOOK, key_len_q != '0, "empty key probed")
endmodule
`default_nettype wire

// ----- tb/sv/keyword_bucket_hash_inserter_tb.sv -----
`timescale 1ns / 1ps

module keyword_bucket_hash_inserter_tb;
	import kbhi_pkg::*;

	localparam int LIMIT_CYCLES = 3000000;
	localparam int HOLD_LEN     = 3000;

	// One predicted or observed result word.
	typedef struct packed {
		status_t     status;
		logic [8:0]  bucket;
		logic        slot;
		logic [31:0] hash;
	} insert_result_t;

	// Scoreboard: its own copy of the table and the key in progress,
	// plus the queue of results still owed by the block.
	class bucket_table_scoreboard;
		logic [TS_W-1:0]   nbuckets;
		logic [MULT_W-1:0] multiplier;
		logic [31:0]       run_hash;
		logic [7:0]        key_buf [MAX_KEY_LEN];
		int                key_len;
		bit                key_ovf;
		bit                row_valid [BUCKETS*WAYS];
		int                row_len   [BUCKETS*WAYS];
		logic [7:0]        row_bytes [BUCKETS*WAYS][MAX_KEY_LEN];
		insert_result_t    owed_results [$];
		int                mismatches;

		function new();
			nbuckets   = TS_RESET;
			multiplier = MULT_RESET;
			mismatches = 0;
			for (int i = 0; i < BUCKETS*WAYS; i++) row_valid[i] = 0;
			restart_key();
		endfunction

		function void restart_key();
			run_hash = 0;
			key_len  = 0;
			key_ovf  = 0;
		endfunction

		function void set_register(logic idx, logic [CFG_W-1:0] val);
			if (idx == CFG_TABLE_SIZE) nbuckets = val[TS_W-1:0];
			else multiplier = val[MULT_W-1:0];
		endfunction

		function bit row_holds_key(int r);
			if (row_len[r] != key_len) return 0;
			for (int i = 0; i < key_len; i++)
				if (row_bytes[r][i] !== key_buf[i]) return 0;
			return 1;
		endfunction

		// Called for each accepted input word.
		function void note_word(logic md, logic [7:0] kb, logic kl);
			insert_result_t r;
			logic [7:0] lc;
			logic [31:0] ts;
			int row;
			if (md == MODE_CLEAR) begin
				for (int i = 0; i < BUCKETS*WAYS; i++) row_valid[i] = 0;
				restart_key();
				r = '{ST_CLEARED, 9'd0, 1'b0, 32'd0};
				owed_results.push_back(r);
				return;
			end
			// only A..Z fold to lower case
			lc = (kb >= 8'h41 && kb <= 8'h5A) ? kb + 8'h20 : kb;
			run_hash = run_hash * {16'd0, multiplier} + {24'd0, lc};
			if (key_len < MAX_KEY_LEN) begin
				key_buf[key_len] = kb;
				key_len++;
			end else key_ovf = 1;
			if (!kl) return;
			ts = nbuckets;
			if (ts == 0) ts = 1;
			if (ts > BUCKETS) ts = BUCKETS;
			r.hash   = run_hash;
			r.bucket = 9'(run_hash % ts);
			r.status = ST_FULL;
			r.slot   = 0;
			if (key_ovf) r.status = ST_TOO_LONG;
			else begin
				for (int w = 0; w < WAYS; w++) begin
					row = r.bucket * WAYS + w;
					if (!row_valid[row]) begin
						row_valid[row] = 1;
						row_len[row]   = key_len;
						for (int i = 0; i < key_len; i++) row_bytes[row][i] = key_buf[i];
						r.status = ST_INSERTED;
						r.slot   = w[0];
						break;
					end
					if (row_holds_key(row)) begin
						r.status = ST_DUPLICATE;
						r.slot   = w[0];
						break;
					end
				end
			end
			restart_key();
			owed_results.push_back(r);
		endfunction

		task report_mismatch(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			mismatches++;
		endtask

		// Called for each accepted output word.
		task check_result(insert_result_t got);
			insert_result_t exp;
			if (owed_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result status=%0d", got.status));
				return;
			end
			exp = owed_results.pop_front();
			if (got.status !== exp.status)
				report_mismatch($sformatf("status %0d, expected %0d", got.status, exp.status));
			if (got.bucket !== exp.bucket)
				report_mismatch($sformatf("bucket %0d, expected %0d", got.bucket, exp.bucket));
			if (got.slot !== exp.slot)
				report_mismatch($sformatf("slot %0d, expected %0d", got.slot, exp.slot));
			if (got.hash !== exp.hash)
				report_mismatch($sformatf("hash %h, expected %h", got.hash, exp.hash));
		endtask
	endclass

	logic              clk = 0;
	logic              arst_n = 0;
	logic              in_valid = 0;
	logic              in_ready;
	logic              mode = MODE_KEY;
	logic [7:0]        key_byte = 0;
	logic              key_last = 0;
	logic              out_valid;
	logic              out_ready = 0;
	logic [2:0]        status;
	logic [8:0]        bucket_index;
	logic              slot_index;
	logic [31:0]       hash_value;
	logic              cfg_we = 0;
	logic              cfg_index = CFG_TABLE_SIZE;
	logic [CFG_W-1:0]  cfg_data = 0;

	keyword_bucket_hash_inserter i_dut (
		.clk, .arst_n, .in_valid, .in_ready, .mode, .key_byte, .key_last,
		.out_valid, .out_ready, .status, .bucket_index, .slot_index, .hash_value,
		.cfg_we, .cfg_index, .cfg_data
	);

	bucket_table_scoreboard sb = new();

	int  send_idle_pct = 0;   // chance of an idle cycle before each word
	int  recv_stall_pct = 0;  // chance of out_ready low per cycle
	bit  hold_request = 0;    // asks the receiver for a long hold-off
	int  cycle_count = 0;
	int  words_sent = 0;
	logic [7:0] key_pool [12][$];

	always #2 clk = ~clk;

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off counted here.
	initial begin
		int hold_cnt;
		hold_cnt = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_cnt = HOLD_LEN;
				hold_request = 0;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Output monitor.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{status_t'(status), bucket_index, slot_index, hash_value});
	end

	// Offer one word and hold it until taken; the scoreboard sees it on the
	// accepting edge. Called at a falling edge, returns at a falling edge.
	task automatic send_word(logic md, logic [7:0] kb, logic kl);
		mode     <= md;
		key_byte <= kb;
		key_last <= kl;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_word(md, kb, kl);
		words_sent++;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic send_key(logic [7:0] bytes [$]);
		foreach (bytes[i]) send_word(MODE_KEY, bytes[i], i == bytes.size() - 1);
	endtask

	// Register write, only once the block has drained; the pause covers
	// a trailing non-last byte still in flight.
	task automatic write_register(logic idx, logic [CFG_W-1:0] val);
		in_valid <= 1'b0;
		while (sb.owed_results.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		sb.set_register(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] random_letter();
		logic [7:0] c;
		c = 8'h61 + 8'($urandom_range(25));
		if ($urandom_range(3) == 0) c = c - 8'h20;
		return c;
	endfunction

	// Mostly reused short keys (duplicates, crowded buckets), some fresh
	// binary keys, some past the length limit, plus clears and junk.
	task automatic random_traffic(int n_words);
		logic [7:0] k [$];
		int sel, len, stop_at;
		stop_at = words_sent + n_words;
		while (words_sent < stop_at) begin
			sel = $urandom_range(99);
			k = {};
			if (sel < 55) begin
				k = key_pool[$urandom_range(11)];
				// flip case of one letter: same hash, different raw key
				if ($urandom_range(4) == 0) begin
					len = $urandom_range(k.size() - 1);
					if (k[len] >= 8'h41 && k[len] <= 8'h5A) k[len] = k[len] + 8'h20;
					else if (k[len] >= 8'h61 && k[len] <= 8'h7A) k[len] = k[len] - 8'h20;
				end
			end else if (sel < 80) begin
				len = $urandom_range(8, 1);
				repeat (len) k.push_back(8'($urandom_range(255)));
			end else if (sel < 88) begin
				len = $urandom_range(23, 19);
				repeat (len) k.push_back(random_letter());
			end else if (sel < 92) begin
				send_word(MODE_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
			end else begin
				// broken key: a few bytes, then a clear drops it
				repeat ($urandom_range(3, 1))
					send_word(MODE_KEY, 8'($urandom_range(255)), 1'b0);
				send_word(MODE_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
			end
			if (k.size() != 0) send_key(k);
		end
	endtask

	initial begin
		logic [CFG_W-1:0] ts_list [8];
		logic [CFG_W-1:0] mult_list [8];
		int send_mix [4];
		int recv_mix [4];

		ts_list   = '{16'd1, 16'd0, 16'd512, 16'd1023, 16'd2, 16'd7, 16'd300, 16'd64};
		mult_list = '{16'd11, 16'd0, 16'd65535, 16'd1, 16'd31, 16'd257, 16'd11, 16'd40503};
		send_mix  = '{0, 74, 0, 6};
		recv_mix  = '{0, 0, 74, 6};

		for (int i = 0; i < 12; i++) begin
			repeat ($urandom_range(6, 1)) key_pool[i].push_back(random_letter());
		end

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset values first, with the table of one bucket for
		// crowding after that.
		send_key('{8'h41, 8'h5A});                // AZ, inserted
		send_key('{8'h61, 8'h7A});                // az, same hash, next slot
		send_key('{8'h41, 8'h5A});                // duplicate
		send_key('{8'h41, 8'h7A});                // same bucket, both full
		send_key('{8'h40, 8'h5B});                // just outside the letter range
		send_word(MODE_KEY, 8'h00, 1'b1);
		send_word(MODE_KEY, 8'hFF, 1'b1);
		send_word(MODE_CLEAR, 8'hFF, 1'b1);       // clear
		send_word(MODE_KEY, 8'h80, 1'b0);
		send_word(MODE_CLEAR, 8'h00, 1'b0);       // clear drops key in progress
		write_register(CFG_TABLE_SIZE, 16'd1);
		write_register(CFG_MULT, 16'd0);          // hash is the case-folded last byte
		send_key('{8'h12, 8'h34, 8'h51});
		send_key('{8'h77, 8'h51});                // same bucket, raw key differs

		for (int p = 0; p < 8; p++) begin
			write_register(CFG_TABLE_SIZE, ts_list[p]);
			write_register(CFG_MULT, mult_list[p]);
			send_idle_pct  = send_mix[p % 4];
			recv_stall_pct = recv_mix[p % 4];
			// receiver holds off while the sender keeps pushing
			if (p == 4) hold_request = 1;
			random_traffic(100);
		end
		in_valid <= 1'b0;

		while (sb.owed_results.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (sb.mismatches == 0 && sb.owed_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
